>>> src/obl_pkg.sv
`default_nettype none

package obl_pkg;

  localparam int PRICE_W = 32;
  localparam int QTY_W   = 32;
  localparam int KEY_W   = PRICE_W + 1;
  localparam int COUNT_W = 7;

  // Event kinds
  localparam logic KIND_SNAPSHOT = 1'b0;
  localparam logic KIND_DELTA    = 1'b1;

  // One word of the key store: side in the top key bit, price below
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } obl_entry_t;

  // Fields of one accepted request
  typedef struct packed {
    logic               kind;
    logic [PRICE_W-1:0] bid_price;
    logic [QTY_W-1:0]   bid_qty;
    logic [PRICE_W-1:0] ask_price;
    logic [QTY_W-1:0]   ask_qty;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic               remove;
    logic [QTY_W-1:0]   qty;
    logic [QTY_W-1:0]   orders;
  } obl_event_t;

  // One result item
  typedef struct packed {
    logic [PRICE_W-1:0] bid_price;
    logic [QTY_W-1:0]   bid_qty;
    logic [PRICE_W-1:0] ask_price;
    logic [QTY_W-1:0]   ask_qty;
    logic [COUNT_W-1:0] used_count;
    logic               dropped;
  } obl_result_t;

endpackage

`default_nettype wire

>>> src/obl_level_mem.sv
`default_nettype none

module obl_level_mem
  import obl_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           key_we,
  input  wire logic                           data_we,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  wire obl_entry_t                     wr_entry,
  input  wire logic [QTY_W-1:0]               wr_qty,
  input  wire logic [QTY_W-1:0]               wr_orders,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output obl_entry_t                          rd_entry
);

  obl_entry_t       key_store  [TABLE_DEPTH];
  logic [2*QTY_W-1:0] level_data [TABLE_DEPTH];

  // Write key and level data, registered key read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_store[wr_addr] <= wr_entry;
    end
    if (data_we) begin
      level_data[wr_addr] <= {wr_qty, wr_orders};
    end
    if (rd_en) begin
      rd_entry <= key_store[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/obl_ctrl.sv
`default_nettype none

module obl_ctrl
  import obl_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           evt_take,
  input  wire obl_event_t                     evt,
  output logic                                busy,
  output logic                                fin_valid,
  input  wire logic                           fin_take,
  output obl_result_t                         fin_res,
  output logic                                key_we,
  output logic                                data_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]      wr_addr,
  output obl_entry_t                          wr_entry,
  output logic [QTY_W-1:0]                    wr_qty,
  output logic [QTY_W-1:0]                    wr_orders,
  output logic                                rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
  input  wire obl_entry_t                     rd_entry
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX   = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t             state;
  logic [PRICE_W-1:0] top_bid_price;
  logic [QTY_W-1:0]   top_bid_qty;
  logic [PRICE_W-1:0] top_ask_price;
  logic [QTY_W-1:0]   top_ask_qty;
  logic [CW-1:0]      used;
  logic [AW-1:0]      idx;
  logic [CW-1:0]      seen;
  logic               free_found;
  logic [AW-1:0]      free_idx;
  logic [KEY_W-1:0]   key;
  logic               remove;
  logic [QTY_W-1:0]   qty;
  logic [QTY_W-1:0]   orders;

  logic          hit_here;
  logic          free_here;
  logic [CW-1:0] seen_next;
  logic          scan_stop;
  logic          scan_done;
  logic [AW-1:0] ins_idx;
  logic          ins_ok;
  logic          act_erase;
  logic          act_update;
  logic          act_insert;
  logic          act_drop;
  logic [CW-1:0] used_next;

  // Compare the entry read last cycle against the request key
  always_comb begin
    hit_here  = rd_entry.valid && (rd_entry.key == key);
    free_here = !rd_entry.valid;
    seen_next = seen + CW'(rd_entry.valid);
    // stop on a match, once every live entry has been seen, or at the end
    scan_stop = hit_here || (seen_next == used) || (idx == LAST_IDX);
    scan_done = (state == ST_SCAN) && scan_stop;
    // past the last live entry everything is free
    ins_idx   = free_found ? free_idx : (free_here ? idx : AW'(idx + 1'b1));
    ins_ok    = free_found || free_here || (idx != LAST_IDX);
    act_erase  = remove && hit_here;
    act_update = !remove && hit_here;
    act_insert = !remove && !hit_here && ins_ok;
    act_drop   = !remove && !hit_here && !ins_ok;
    if (act_erase) begin
      used_next = used - CW'(1);
    end else if (act_insert) begin
      used_next = used + CW'(1);
    end else begin
      used_next = used;
    end
  end

  // Memory ports: clearing pass, scan reads, write-back at the end of a scan
  always_comb begin
    key_we         = (state == ST_CLEAR) || (scan_done && (act_erase || act_insert));
    data_we        = scan_done && (act_update || act_insert);
    wr_addr        = (state == ST_CLEAR || hit_here) ? idx : ins_idx;
    wr_entry.valid = (state == ST_SCAN) && !remove;
    wr_entry.key   = key;
    wr_qty         = qty;
    wr_orders      = orders;
    rd_en          = ((state == ST_IDLE) && evt_take && (evt.kind == KIND_DELTA)) ||
                     ((state == ST_SCAN) && !scan_stop);
    rd_addr        = (state == ST_SCAN) ? AW'(idx + 1'b1) : '0;
  end

  assign busy      = (state != ST_IDLE);
  assign fin_valid = (state == ST_FIN);

  // Sequencer: clear, take a request, scan for a delta, hand over the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      idx           <= '0;
      used          <= '0;
      top_bid_price <= '0;
      top_bid_qty   <= '0;
      top_ask_price <= '0;
      top_ask_qty   <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          idx <= AW'(idx + 1'b1);
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (evt_take) begin
            if (evt.kind == KIND_SNAPSHOT) begin
              top_bid_price <= evt.bid_price;
              top_bid_qty   <= evt.bid_qty;
              top_ask_price <= evt.ask_price;
              top_ask_qty   <= evt.ask_qty;
              fin_res <= '{bid_price: evt.bid_price, bid_qty: evt.bid_qty,
                           ask_price: evt.ask_price, ask_qty: evt.ask_qty,
                           used_count: COUNT_W'(used), dropped: 1'b0};
              state   <= ST_FIN;
            end else begin
              key        <= {evt.side, evt.price};
              remove     <= evt.remove;
              qty        <= evt.qty;
              orders     <= evt.orders;
              idx        <= '0;
              seen       <= '0;
              free_found <= 1'b0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_stop) begin
            used    <= used_next;
            fin_res <= '{bid_price: top_bid_price, bid_qty: top_bid_qty,
                         ask_price: top_ask_price, ask_qty: top_ask_qty,
                         used_count: COUNT_W'(used_next), dropped: act_drop};
            state   <= ST_FIN;
          end else begin
            idx  <= AW'(idx + 1'b1);
            seen <= seen_next;
            if (!free_found && free_here) begin
              free_found <= 1'b1;
              free_idx   <= idx;
            end
          end
        end
        ST_FIN: begin
          if (fin_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= FULL_COUNT)
    else $error("level count above table depth");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (scan_done && act_drop) |-> (used == FULL_COUNT))
    else $error("insert dropped while table has a free slot");

  a_quiet_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_FIN) |-> !(key_we || data_we))
    else $error("table written outside clear or scan");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !fin_take) |=> (state == ST_FIN && $stable(fin_res)))
    else $error("result lost before hand-over");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && idx == LAST_IDX) |-> scan_stop)
    else $error("scan ran past the last entry");

endmodule

`default_nettype wire

>>> src/order_book_level_table_unit.sv
// Order book level table.
// Request channel (evt_valid / evt_stall): kind 0 is a top-of-book snapshot
// that overwrites the stored best bid and ask; kind 1 is a level delta keyed
// by {level_side, level_price} that erases, updates or inserts a level.
// Result channel (res_valid / res_stall): one result per request with the
// stored top of book, the live level count and the dropped flag.
// A snapshot's result is registered in the controller, then in the output
// register. A delta reads the key store one entry a cycle from entry 0 and
// stops on a match, once every live entry has been seen, or at the end of
// the table; the key store has a single read port. A new request is not
// taken until the last one has passed its result to the output register.
// evt_stall is high while a request is in progress.
// Reset: the key store is swept clear, one entry a cycle, with evt_stall
// high; top of book and the level count go to zero.
// A stalled result holds in the output register; the next request is still
// taken and worked, and waits for the register before its result moves on.
`default_nettype none

module order_book_level_table_unit
  import obl_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               evt_valid,
  output logic                    evt_stall,
  input  wire logic               kind,
  input  wire logic [PRICE_W-1:0] new_bid_price,
  input  wire logic [QTY_W-1:0]   new_bid_qty,
  input  wire logic [PRICE_W-1:0] new_ask_price,
  input  wire logic [QTY_W-1:0]   new_ask_qty,
  input  wire logic               level_side,
  input  wire logic [PRICE_W-1:0] level_price,
  input  wire logic               level_remove,
  input  wire logic [QTY_W-1:0]   level_qty,
  input  wire logic [QTY_W-1:0]   level_orders,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic [PRICE_W-1:0]      out_bid_price,
  output logic [QTY_W-1:0]        out_bid_qty,
  output logic [PRICE_W-1:0]      out_ask_price,
  output logic [QTY_W-1:0]        out_ask_qty,
  output logic [COUNT_W-1:0]      used_count,
  output logic                    dropped
);

  localparam int AW = $clog2(TABLE_DEPTH);

  obl_event_t    evt;
  logic          evt_take;
  logic          busy;
  logic          fin_valid;
  logic          fin_take;
  obl_result_t   fin_res;
  obl_result_t   res;
  logic          key_we;
  logic          data_we;
  logic [AW-1:0] wr_addr;
  obl_entry_t    wr_entry;
  logic [QTY_W-1:0] wr_qty;
  logic [QTY_W-1:0] wr_orders;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  obl_entry_t    rd_entry;

  // Gather the request fields
  always_comb begin
    evt.kind      = kind;
    evt.bid_price = new_bid_price;
    evt.bid_qty   = new_bid_qty;
    evt.ask_price = new_ask_price;
    evt.ask_qty   = new_ask_qty;
    evt.side      = level_side;
    evt.price     = level_price;
    evt.remove    = level_remove;
    evt.qty       = level_qty;
    evt.orders    = level_orders;
  end

  assign evt_stall = busy;
  assign evt_take  = evt_valid && !busy;
  assign fin_take  = fin_valid && (!res_valid || !res_stall);

  obl_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_take  (evt_take),
    .evt       (evt),
    .busy      (busy),
    .fin_valid (fin_valid),
    .fin_take  (fin_take),
    .fin_res   (fin_res),
    .key_we    (key_we),
    .data_we   (data_we),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .wr_qty    (wr_qty),
    .wr_orders (wr_orders),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_entry  (rd_entry)
  );

  obl_level_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk       (clk),
    .key_we    (key_we),
    .data_we   (data_we),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .wr_qty    (wr_qty),
    .wr_orders (wr_orders),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_entry  (rd_entry)
  );

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      res <= fin_res;
    end
  end

  assign out_bid_price = res.bid_price;
  assign out_bid_qty   = res.bid_qty;
  assign out_ask_price = res.ask_price;
  assign out_ask_qty   = res.ask_qty;
  assign used_count    = res.used_count;
  assign dropped       = res.dropped;

endmodule

`default_nettype wire

>>> bench/order_book_level_table_checker.sv
`default_nettype none

module order_book_level_table_checker
  import obl_pkg::*;
#(
  parameter int BOOK_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               evt_valid,
  input  wire logic               evt_stall,
  input  wire logic               kind,
  input  wire logic [PRICE_W-1:0] new_bid_price,
  input  wire logic [QTY_W-1:0]   new_bid_qty,
  input  wire logic [PRICE_W-1:0] new_ask_price,
  input  wire logic [QTY_W-1:0]   new_ask_qty,
  input  wire logic               level_side,
  input  wire logic [PRICE_W-1:0] level_price,
  input  wire logic               level_remove,
  input  wire logic [QTY_W-1:0]   level_qty,
  input  wire logic [QTY_W-1:0]   level_orders,
  input  wire logic               res_valid,
  input  wire logic               res_stall,
  input  wire logic [PRICE_W-1:0] out_bid_price,
  input  wire logic [QTY_W-1:0]   out_bid_qty,
  input  wire logic [PRICE_W-1:0] out_ask_price,
  input  wire logic [QTY_W-1:0]   out_ask_qty,
  input  wire logic [COUNT_W-1:0] used_count,
  input  wire logic               dropped,
  output int                      fail_count,
  output int                      pending_count,
  output int                      result_count
);

  timeunit 1ns;
  timeprecision 1ps;

  // Shadow book
  logic [PRICE_W-1:0] shadow_bid_price;
  logic [QTY_W-1:0]   best_bid_sz;
  logic [PRICE_W-1:0] shadow_ask_price;
  logic [QTY_W-1:0]   best_ask_sz;
  logic               level_live [BOOK_DEPTH];
  logic [KEY_W-1:0]   level_key [BOOK_DEPTH];
  logic [QTY_W-1:0]   level_size [BOOK_DEPTH];
  logic [QTY_W-1:0]   level_count [BOOK_DEPTH];
  logic [COUNT_W-1:0] levels_in_use;

  obl_result_t book_results_due[$];
  obl_event_t  seen_request;
  obl_result_t seen_result;
  int          errors;
  int          results_taken;

  assign seen_request = {kind, new_bid_price, new_bid_qty, new_ask_price, new_ask_qty,
                         level_side, level_price, level_remove, level_qty, level_orders};
  assign seen_result  = {out_bid_price, out_bid_qty, out_ask_price, out_ask_qty,
                         used_count, dropped};

  initial begin
    errors = 0;
    results_taken = 0;
    fail_count = 0;
    pending_count = 0;
    result_count = 0;
  end

  // Apply one request to the shadow book and return the result it should give
  function automatic obl_result_t apply_book_event(input obl_event_t ev);
    obl_result_t      res;
    logic [KEY_W-1:0] key;
    int               hit;
    int               slot;
    int               i;
    res.dropped = 1'b0;
    if (ev.kind == KIND_SNAPSHOT) begin
      shadow_bid_price = ev.bid_price;
      best_bid_sz      = ev.bid_qty;
      shadow_ask_price = ev.ask_price;
      best_ask_sz      = ev.ask_qty;
    end else begin
      key  = {ev.side, ev.price};
      hit  = -1;
      slot = -1;
      for (i = 0; i < BOOK_DEPTH; i++) begin
        if (level_live[i]) begin
          if (hit < 0 && level_key[i] == key) hit = i;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (ev.remove) begin
        if (hit >= 0) begin
          level_live[hit] = 1'b0;
          if (levels_in_use != '0) levels_in_use--;
        end
      end else if (hit >= 0) begin
        level_size[hit]  = ev.qty;
        level_count[hit] = ev.orders;
      end else if (slot >= 0) begin
        level_live[slot]  = 1'b1;
        level_key[slot]   = key;
        level_size[slot]  = ev.qty;
        level_count[slot] = ev.orders;
        levels_in_use++;
      end else begin
        res.dropped = 1'b1;
      end
    end
    res.bid_price  = shadow_bid_price;
    res.bid_qty    = best_bid_sz;
    res.ask_price  = shadow_ask_price;
    res.ask_qty    = best_ask_sz;
    res.used_count = levels_in_use;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare taken results before queueing the request of the same edge
  always @(posedge clk) begin
    obl_result_t want;
    if (rst) begin
      shadow_bid_price = '0;
      best_bid_sz      = '0;
      shadow_ask_price = '0;
      best_ask_sz      = '0;
      levels_in_use = '0;
      for (int i = 0; i < BOOK_DEPTH; i++) level_live[i] = 1'b0;
      book_results_due.delete();
    end else begin
      if (res_valid && !res_stall) begin
        results_taken++;
        if (book_results_due.size() == 0) begin
          $display("%0t ns: result with no request outstanding, got %h", $time, seen_result);
          errors++;
        end else begin
          want = book_results_due.pop_front();
          check_field("out_bid_price", want.bid_price, seen_result.bid_price);
          check_field("out_bid_qty", want.bid_qty, seen_result.bid_qty);
          check_field("out_ask_price", want.ask_price, seen_result.ask_price);
          check_field("out_ask_qty", want.ask_qty, seen_result.ask_qty);
          check_field("used_count", 32'(want.used_count), 32'(seen_result.used_count));
          check_field("dropped", 32'(want.dropped), 32'(seen_result.dropped));
        end
      end
      if (evt_valid && !evt_stall) book_results_due.push_back(apply_book_event(seen_request));
    end
    fail_count    <= errors;
    pending_count <= book_results_due.size();
    result_count  <= results_taken;
  end

endmodule

`default_nettype wire

>>> bench/order_book_level_table_unit_tb.sv
`default_nettype none

module order_book_level_table_unit_tb
  import obl_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int   BOOK_DEPTH     = 64;
  localparam int   POOL_KEYS      = 80;
  localparam int   TOTAL_REQUESTS = 1100;
  localparam logic SIDE_BID       = 1'b0;
  localparam logic SIDE_ASK       = 1'b1;
  localparam logic LEVEL_KEEP     = 1'b0;
  localparam logic LEVEL_ERASE    = 1'b1;

  logic               clk = 1'b0;
  logic               rst;
  logic               evt_valid;
  logic               evt_stall;
  logic               kind;
  logic [PRICE_W-1:0] new_bid_price;
  logic [QTY_W-1:0]   new_bid_qty;
  logic [PRICE_W-1:0] new_ask_price;
  logic [QTY_W-1:0]   new_ask_qty;
  logic               level_side;
  logic [PRICE_W-1:0] level_price;
  logic               level_remove;
  logic [QTY_W-1:0]   level_qty;
  logic [QTY_W-1:0]   level_orders;
  logic               res_valid;
  logic               res_stall;
  logic [PRICE_W-1:0] out_bid_price;
  logic [QTY_W-1:0]   out_bid_qty;
  logic [PRICE_W-1:0] out_ask_price;
  logic [QTY_W-1:0]   out_ask_qty;
  logic [COUNT_W-1:0] used_count;
  logic               dropped;

  int fail_count;
  int pending_count;
  int result_count;
  int requests_sent;
  bit calm;

  logic               pool_side [POOL_KEYS];
  logic [PRICE_W-1:0] pool_price [POOL_KEYS];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  order_book_level_table_unit #(
    .TABLE_DEPTH(BOOK_DEPTH)
  ) u_top (
    .clk(clk), .rst(rst),
    .evt_valid(evt_valid), .evt_stall(evt_stall),
    .kind(kind),
    .new_bid_price(new_bid_price), .new_bid_qty(new_bid_qty),
    .new_ask_price(new_ask_price), .new_ask_qty(new_ask_qty),
    .level_side(level_side), .level_price(level_price), .level_remove(level_remove),
    .level_qty(level_qty), .level_orders(level_orders),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_bid_price(out_bid_price), .out_bid_qty(out_bid_qty),
    .out_ask_price(out_ask_price), .out_ask_qty(out_ask_qty),
    .used_count(used_count), .dropped(dropped)
  );

  order_book_level_table_checker #(
    .BOOK_DEPTH(BOOK_DEPTH)
  ) u_checker (
    .clk(clk), .rst(rst),
    .evt_valid(evt_valid), .evt_stall(evt_stall),
    .kind(kind),
    .new_bid_price(new_bid_price), .new_bid_qty(new_bid_qty),
    .new_ask_price(new_ask_price), .new_ask_qty(new_ask_qty),
    .level_side(level_side), .level_price(level_price), .level_remove(level_remove),
    .level_qty(level_qty), .level_orders(level_orders),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_bid_price(out_bid_price), .out_bid_qty(out_bid_qty),
    .out_ask_price(out_ask_price), .out_ask_qty(out_ask_qty),
    .used_count(used_count), .dropped(dropped),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  // Words biased towards the extremes
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h0000_0000;
    if (r < 20) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Drive one request at the falling edge and hold it until taken
  task automatic offer_request(input obl_event_t ev);
    int gap;
    @(negedge clk);
    kind          = ev.kind;
    new_bid_price = ev.bid_price;
    new_bid_qty   = ev.bid_qty;
    new_ask_price = ev.ask_price;
    new_ask_qty   = ev.ask_qty;
    level_side    = ev.side;
    level_price   = ev.price;
    level_remove  = ev.remove;
    level_qty     = ev.qty;
    level_orders  = ev.orders;
    evt_valid     = 1'b1;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    requests_sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      evt_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Snapshot with noise in the level fields
  task automatic put_snapshot(input logic [31:0] bid_px, input logic [31:0] bid_sz,
                              input logic [31:0] ask_px, input logic [31:0] ask_sz);
    obl_event_t ev;
    ev = {KIND_SNAPSHOT, bid_px, bid_sz, ask_px, ask_sz, 1'($urandom_range(0, 1)),
          32'($urandom()), 1'($urandom_range(0, 1)), 32'($urandom()), 32'($urandom())};
    offer_request(ev);
  endtask

  // Level delta with noise in the snapshot fields
  task automatic put_level(input logic side, input logic [31:0] px, input logic erase,
                           input logic [31:0] sz, input logic [31:0] orders);
    obl_event_t ev;
    ev = {KIND_DELTA, 32'($urandom()), 32'($urandom()), 32'($urandom()), 32'($urandom()),
          side, px, erase, sz, orders};
    offer_request(ev);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_until_drained();
    @(negedge clk);
    evt_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Result side: random stalls plus two long hold-offs
  initial begin
    int hold_left;
    int r;
    bit held_early;
    bit held_late;
    hold_left  = 0;
    held_early = 1'b0;
    held_late  = 1'b0;
    res_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_early && result_count >= 100) begin
        held_early = 1'b1;
        hold_left  = 300;
      end else if (!held_late && result_count >= 700) begin
        held_late = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        res_stall = 1'b1;
        hold_left--;
      end else if (calm) begin
        res_stall = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          res_stall = 1'b0;
        end else if (r < 90) begin
          res_stall = 1'b1;
          hold_left = $urandom_range(0, 2);
        end else begin
          res_stall = 1'b1;
          hold_left = $urandom_range(4, 39);
        end
      end
    end
  end

  // Request side
  initial begin
    int         phase;
    int         erase_pct;
    int         n;
    int         k;
    int         r;
    bit         drained_mid;
    logic       side;
    logic [31:0] px;
    rst           = 1'b1;
    evt_valid     = 1'b0;
    kind          = KIND_SNAPSHOT;
    new_bid_price = '0;
    new_bid_qty   = '0;
    new_ask_price = '0;
    new_ask_qty   = '0;
    level_side    = SIDE_BID;
    level_price   = '0;
    level_remove  = LEVEL_KEEP;
    level_qty     = '0;
    level_orders  = '0;
    requests_sent = 0;
    calm          = 1'b0;
    drained_mid   = 1'b0;

    // Key pool: each price on both sides, extremes included
    for (int j = 0; j < POOL_KEYS / 2; j++) begin
      if (j == 0) px = 32'h0000_0000;
      else if (j == 1) px = 32'hFFFF_FFFF;
      else px = ($urandom() & 32'hFFFF_FF00) | 32'(j);
      pool_price[2 * j]     = px;
      pool_side[2 * j]      = SIDE_BID;
      pool_price[2 * j + 1] = px;
      pool_side[2 * j + 1]  = SIDE_ASK;
    end

    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, erase with and without a match, slot reuse
    put_snapshot(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    put_snapshot(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_level(SIDE_ASK, 32'hFFFF_FFFF, LEVEL_ERASE, 32'h1, 32'h1);
    put_level(SIDE_BID, 32'h0000_0000, LEVEL_KEEP, 32'h0000_0000, 32'h0000_0000);
    put_level(SIDE_ASK, 32'h0000_0000, LEVEL_KEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_level(SIDE_BID, 32'h0000_0000, LEVEL_KEEP, 32'hFFFF_FFFF, 32'h5555_5555);
    put_level(SIDE_BID, 32'hFFFF_FFFF, LEVEL_KEEP, 32'hAAAA_AAAA, 32'h0000_0000);
    put_level(SIDE_ASK, 32'hFFFF_FFFF, LEVEL_KEEP, 32'h5555_5555, 32'hAAAA_AAAA);
    put_level(SIDE_ASK, 32'h0000_0000, LEVEL_ERASE, 32'h0, 32'h0);
    put_level(SIDE_ASK, 32'h0000_0000, LEVEL_ERASE, 32'h0, 32'h0);
    put_level(SIDE_BID, 32'h5555_5555, LEVEL_KEEP, 32'h1234_5678, 32'h0000_0001);
    put_level(SIDE_ASK, 32'h0000_0000, LEVEL_KEEP, 32'h0000_0007, 32'h0000_0003);
    put_level(SIDE_BID, 32'h0000_0000, LEVEL_ERASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_level(SIDE_ASK, 32'hAAAA_AAAA, LEVEL_KEEP, 32'h0000_0001, 32'hFFFF_FFFF);
    put_level(SIDE_BID, 32'hFFFF_FFFF, LEVEL_KEEP, 32'h0000_0002, 32'h0000_0002);
    put_snapshot(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    put_snapshot(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    put_level(SIDE_BID, 32'hFFFF_FFFF, LEVEL_ERASE, 32'h0, 32'h0);
    put_level(SIDE_ASK, 32'hFFFF_FFFF, LEVEL_ERASE, 32'h0, 32'h0);
    put_level(SIDE_BID, 32'hAAAA_AAAA, LEVEL_ERASE, 32'h0, 32'h0);
    wait_until_drained();

    // Fill past capacity so the last inserts are dropped, updates hit while full
    for (int j = 0; j < 70; j++)
      put_level(pool_side[j], pool_price[j], LEVEL_KEEP, pick_word(), pick_word());
    for (int j = 0; j < 6; j++) begin
      k = $urandom_range(0, 69);
      put_level(pool_side[k], pool_price[k], LEVEL_KEEP, pick_word(), pick_word());
    end

    // Random rounds cycling through fill, churn and drain
    phase = 0;
    while (requests_sent < TOTAL_REQUESTS) begin
      calm = ($urandom_range(0, 3) == 0);
      erase_pct = (phase % 3 == 0) ? 15 : (phase % 3 == 1) ? 40 : 70;
      n = $urandom_range(20, 80);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          put_snapshot(pick_word(), pick_word(), pick_word(), pick_word());
        end else begin
          if ($urandom_range(0, 9) == 0) begin
            side = 1'($urandom_range(0, 1));
            px   = $urandom();
          end else begin
            k    = $urandom_range(0, POOL_KEYS - 1);
            side = pool_side[k];
            px   = pool_price[k];
          end
          put_level(side, px, ($urandom_range(0, 99) < erase_pct) ? LEVEL_ERASE : LEVEL_KEEP,
                    pick_word(), pick_word());
        end
      end
      phase++;
      // Pause once mid-run until the book has answered everything
      if (!drained_mid && requests_sent > TOTAL_REQUESTS / 2) begin
        drained_mid = 1'b1;
        wait_until_drained();
      end
    end

    wait_until_drained();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/obl_pkg.sv
src/obl_level_mem.sv
src/obl_ctrl.sv
src/order_book_level_table_unit.sv
bench/order_book_level_table_checker.sv
bench/order_book_level_table_unit_tb.sv
